// ===== rtl/tct_pkg.sv =====
// Shared constants and types for the triangle tile coverage block.
package tct_pkg;

   localparam int TILE_SIZE     = 8;
   localparam int FRACTION_BITS = 4;

   localparam int CW    = 16;                          // vertex coordinate width
   localparam int TW    = 9;                           // tile index width
   localparam int SCRW  = 13;                          // screen size register width
   localparam int XW    = TW + $clog2(TILE_SIZE);      // pixel coordinate width
   localparam int SXW   = XW + FRACTION_BITS;          // pixel scaled to fixed point
   localparam int DW    = ((SXW > CW) ? SXW : CW) + 1; // vertex difference width
   localparam int PW    = 2 * DW;                      // product width
   localparam int EW    = PW + 4;                      // edge function width
   localparam int RW    = CW + 1;                      // rounded bound width
   localparam int COVW  = 64;
   localparam int HALF  = (1 << FRACTION_BITS) >> 1;
   localparam int NST   = 8;                           // pipeline register stages

   localparam logic [SCRW-1:0] WIDTH_RESET  = SCRW'(640);
   localparam logic [SCRW-1:0] HEIGHT_RESET = SCRW'(480);

   typedef enum logic {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [TILE_SIZE-1:0] lane_mask_type;

   typedef struct packed {
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by_coord;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [TW-1:0] tile_col;
      logic signed [TW-1:0] tile_row;
   } req_type;

   typedef struct packed {
      logic signed [PW-1:0] pda;
      logic signed [PW-1:0] pdb;
      logic signed [PW-1:0] psa;
      logic signed [PW-1:0] psb;
      logic signed [PW-1:0] pta;
      logic signed [PW-1:0] ptb;
      logic signed [DW-1:0] ux;
      logic signed [DW-1:0] uy;
      logic signed [DW-1:0] vx;
      logic signed [DW-1:0] vy;
      lane_mask_type        colmask;
      lane_mask_type        rowmask;
   } prod_type;

   // edge functions: 0 = s, 1 = t, 2 = 1 - s - t (all scaled by |D|)
   typedef struct packed {
      logic [2:0][EW-1:0] base;
      logic [2:0][EW-1:0] colstep;
      logic [2:0][EW-1:0] rowstep;
      lane_mask_type      colmask;
      lane_mask_type      rowmask;
      logic               degen;
   } edge_type;

   typedef struct packed {
      logic [COVW-1:0] cov;
      logic            degen;
   } cov_type;

endpackage

// ===== rtl/tct_req_if.sv =====
// Request channel: one triangle and one tile position.
interface tct_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [tct_pkg::CW-1:0]  ax;
   logic signed [tct_pkg::CW-1:0]  ay;
   logic signed [tct_pkg::CW-1:0]  bx;
   logic signed [tct_pkg::CW-1:0]  by_coord;
   logic signed [tct_pkg::CW-1:0]  cx;
   logic signed [tct_pkg::CW-1:0]  cy;
   logic signed [tct_pkg::TW-1:0]  tile_col;
   logic signed [tct_pkg::TW-1:0]  tile_row;

   modport source (output valid, ax, ay, bx, by_coord, cx, cy, tile_col, tile_row,
                   input ready);
   modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, tile_col, tile_row,
                   output ready);
endinterface

// ===== rtl/tct_rsp_if.sv =====
// Response channel: tile coverage mask and flags.
interface tct_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tct_pkg::COVW-1:0]    coverage;
   logic                        degenerate;
   logic                        any_hit;

   modport source (output valid, coverage, degenerate, any_hit, input ready);
   modport sink   (input valid, coverage, degenerate, any_hit, output ready);
endinterface

// ===== rtl/tct_setup.sv =====
// Setup stages: vertex differences, rounded box, clip lanes, edge products.
module tct_setup (
   input  logic                            clock,
   input  logic [1:0]                      en,
   input  tct_pkg::req_type                req,
   input  logic [tct_pkg::SCRW-1:0]        screen_width,
   input  logic [tct_pkg::SCRW-1:0]        screen_height,
   output tct_pkg::prod_type               prod
);

   typedef struct packed {
      logic signed [tct_pkg::DW-1:0] ux;
      logic signed [tct_pkg::DW-1:0] uy;
      logic signed [tct_pkg::DW-1:0] vx;
      logic signed [tct_pkg::DW-1:0] vy;
      logic signed [tct_pkg::DW-1:0] wx0;
      logic signed [tct_pkg::DW-1:0] wy0;
      logic signed [tct_pkg::RW-1:0] x0;
      logic signed [tct_pkg::RW-1:0] x1;
      logic signed [tct_pkg::RW-1:0] y0;
      logic signed [tct_pkg::RW-1:0] y1;
      logic signed [tct_pkg::XW-1:0] ox;
      logic signed [tct_pkg::XW-1:0] oy;
   } setup_type;

   setup_type          s1_in, s1_ff;
   tct_pkg::prod_type  s2_in, s2_ff;

   function automatic logic signed [tct_pkg::CW-1:0] min3(
      input logic signed [tct_pkg::CW-1:0] a,
      input logic signed [tct_pkg::CW-1:0] b,
      input logic signed [tct_pkg::CW-1:0] c);
      logic signed [tct_pkg::CW-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [tct_pkg::CW-1:0] max3(
      input logic signed [tct_pkg::CW-1:0] a,
      input logic signed [tct_pkg::CW-1:0] b,
      input logic signed [tct_pkg::CW-1:0] c);
      logic signed [tct_pkg::CW-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // floor((v + half) / 2^F)
   function automatic logic signed [tct_pkg::RW-1:0] round_px(
      input logic signed [tct_pkg::CW-1:0] v);
      logic signed [tct_pkg::RW-1:0] n;
      n = tct_pkg::RW'(v) + tct_pkg::RW'(tct_pkg::HALF);
      return n >>> tct_pkg::FRACTION_BITS;
   endfunction

   always_comb begin
      logic signed [tct_pkg::DW-1:0] axe, aye;
      axe = tct_pkg::DW'(req.ax);
      aye = tct_pkg::DW'(req.ay);
      s1_in.ux  = tct_pkg::DW'(req.bx) - axe;
      s1_in.uy  = tct_pkg::DW'(req.by_coord) - aye;
      s1_in.vx  = tct_pkg::DW'(req.cx) - axe;
      s1_in.vy  = tct_pkg::DW'(req.cy) - aye;
      s1_in.ox  = tct_pkg::XW'(req.tile_col * tct_pkg::TILE_SIZE);
      s1_in.oy  = tct_pkg::XW'(req.tile_row * tct_pkg::TILE_SIZE);
      s1_in.wx0 = (tct_pkg::DW'(s1_in.ox) <<< tct_pkg::FRACTION_BITS) - axe;
      s1_in.wy0 = (tct_pkg::DW'(s1_in.oy) <<< tct_pkg::FRACTION_BITS) - aye;
      s1_in.x0  = round_px(min3(req.ax, req.bx, req.cx));
      s1_in.x1  = round_px(max3(req.ax, req.bx, req.cx));
      s1_in.y0  = round_px(min3(req.ay, req.by_coord, req.cy));
      s1_in.y1  = round_px(max3(req.ay, req.by_coord, req.cy));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff <= s1_in;
      end
   end

   always_comb begin
      logic [tct_pkg::SCRW-1:0]      hw, hh;
      logic signed [tct_pkg::XW-1:0] x, y;
      logic [tct_pkg::XW-1:0]        ax_abs, ay_abs;
      logic signed [tct_pkg::RW-1:0] xe, ye;
      hw = screen_width >> 1;
      hh = screen_height >> 1;
      s2_in.pda = tct_pkg::PW'(s1_ff.ux)  * tct_pkg::PW'(s1_ff.vy);
      s2_in.pdb = tct_pkg::PW'(s1_ff.uy)  * tct_pkg::PW'(s1_ff.vx);
      s2_in.psa = tct_pkg::PW'(s1_ff.wx0) * tct_pkg::PW'(s1_ff.vy);
      s2_in.psb = tct_pkg::PW'(s1_ff.wy0) * tct_pkg::PW'(s1_ff.vx);
      s2_in.pta = tct_pkg::PW'(s1_ff.ux)  * tct_pkg::PW'(s1_ff.wy0);
      s2_in.ptb = tct_pkg::PW'(s1_ff.uy)  * tct_pkg::PW'(s1_ff.wx0);
      s2_in.ux  = s1_ff.ux;
      s2_in.uy  = s1_ff.uy;
      s2_in.vx  = s1_ff.vx;
      s2_in.vy  = s1_ff.vy;
      for (int i = 0; i < tct_pkg::TILE_SIZE; i++) begin
         x = s1_ff.ox + tct_pkg::XW'(i);
         y = s1_ff.oy + tct_pkg::XW'(i);
         ax_abs = x[tct_pkg::XW-1] ? tct_pkg::XW'(-x) : tct_pkg::XW'(x);
         ay_abs = y[tct_pkg::XW-1] ? tct_pkg::XW'(-y) : tct_pkg::XW'(y);
         xe = tct_pkg::RW'(x);
         ye = tct_pkg::RW'(y);
         s2_in.colmask[i] = (xe >= s1_ff.x0) && (xe < s1_ff.x1) &&
                            (tct_pkg::SCRW'(ax_abs) < hw);
         s2_in.rowmask[i] = (ye >= s1_ff.y0) && (ye < s1_ff.y1) &&
                            (tct_pkg::SCRW'(ay_abs) < hh);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_ff <= s2_in;
      end
   end

   assign prod = s2_ff;

endmodule

// ===== rtl/tct_edge.sv =====
// Edge stages: determinant, origin edge values, sign fold, per-step increments.
module tct_edge (
   input  logic                clock,
   input  logic [2:0]          en,
   input  tct_pkg::prod_type   prod,
   output tct_pkg::edge_type   edge_out
);

   typedef struct packed {
      logic signed [tct_pkg::EW-1:0] det;
      logic signed [tct_pkg::EW-1:0] es;
      logic signed [tct_pkg::EW-1:0] et;
      logic signed [tct_pkg::DW-1:0] ux;
      logic signed [tct_pkg::DW-1:0] uy;
      logic signed [tct_pkg::DW-1:0] vx;
      logic signed [tct_pkg::DW-1:0] vy;
      tct_pkg::lane_mask_type        colmask;
      tct_pkg::lane_mask_type        rowmask;
   } raw_type;

   typedef struct packed {
      logic signed [tct_pkg::EW-1:0] absdet;
      logic signed [tct_pkg::EW-1:0] es;
      logic signed [tct_pkg::EW-1:0] et;
      logic signed [tct_pkg::EW-1:0] csx;
      logic signed [tct_pkg::EW-1:0] csy;
      logic signed [tct_pkg::EW-1:0] ctx;
      logic signed [tct_pkg::EW-1:0] cty;
      tct_pkg::lane_mask_type        colmask;
      tct_pkg::lane_mask_type        rowmask;
      logic                          degen;
   } fold_type;

   raw_type            s3_in, s3_ff;
   fold_type           s4_in, s4_ff;
   tct_pkg::edge_type  s5_in, s5_ff;

   always_comb begin
      s3_in.det     = tct_pkg::EW'(prod.pda) - tct_pkg::EW'(prod.pdb);
      s3_in.es      = tct_pkg::EW'(prod.psa) - tct_pkg::EW'(prod.psb);
      s3_in.et      = tct_pkg::EW'(prod.pta) - tct_pkg::EW'(prod.ptb);
      s3_in.ux      = prod.ux;
      s3_in.uy      = prod.uy;
      s3_in.vx      = prod.vx;
      s3_in.vy      = prod.vy;
      s3_in.colmask = prod.colmask;
      s3_in.rowmask = prod.rowmask;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s3_ff <= s3_in;
      end
   end

   // one pixel step moves w by 2^F; multiply everything by sign(D)
   always_comb begin
      logic                          neg;
      logic signed [tct_pkg::EW-1:0] sx, sy, tx, ty;
      neg = s3_ff.det[tct_pkg::EW-1];
      sx  =   tct_pkg::EW'(s3_ff.vy) <<< tct_pkg::FRACTION_BITS;
      sy  = -(tct_pkg::EW'(s3_ff.vx) <<< tct_pkg::FRACTION_BITS);
      tx  = -(tct_pkg::EW'(s3_ff.uy) <<< tct_pkg::FRACTION_BITS);
      ty  =   tct_pkg::EW'(s3_ff.ux) <<< tct_pkg::FRACTION_BITS;
      s4_in.absdet  = neg ? -s3_ff.det : s3_ff.det;
      s4_in.es      = neg ? -s3_ff.es  : s3_ff.es;
      s4_in.et      = neg ? -s3_ff.et  : s3_ff.et;
      s4_in.csx     = neg ? -sx : sx;
      s4_in.csy     = neg ? -sy : sy;
      s4_in.ctx     = neg ? -tx : tx;
      s4_in.cty     = neg ? -ty : ty;
      s4_in.degen   = (s3_ff.det == '0);
      s4_in.colmask = s3_ff.colmask;
      s4_in.rowmask = s3_ff.rowmask;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s4_ff <= s4_in;
      end
   end

   always_comb begin
      s5_in.base[0]    = s4_ff.es;
      s5_in.base[1]    = s4_ff.et;
      s5_in.base[2]    = s4_ff.absdet - s4_ff.es - s4_ff.et;
      s5_in.colstep[0] = s4_ff.csx;
      s5_in.colstep[1] = s4_ff.ctx;
      s5_in.colstep[2] = -(s4_ff.csx + s4_ff.ctx);
      s5_in.rowstep[0] = s4_ff.csy;
      s5_in.rowstep[1] = s4_ff.cty;
      s5_in.rowstep[2] = -(s4_ff.csy + s4_ff.cty);
      s5_in.colmask    = s4_ff.colmask;
      s5_in.rowmask    = s4_ff.rowmask;
      s5_in.degen      = s4_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s5_ff <= s5_in;
      end
   end

   assign edge_out = s5_ff;

endmodule

// ===== rtl/tct_raster.sv =====
// Raster stages: row bases and column offsets, then the per-pixel test.
module tct_raster (
   input  logic                clock,
   input  logic [1:0]          en,
   input  tct_pkg::edge_type   edge_in,
   output tct_pkg::cov_type    cov
);

   typedef struct packed {
      logic [2:0][tct_pkg::TILE_SIZE-1:0][tct_pkg::EW-1:0] rowbase;
      logic [2:0][tct_pkg::TILE_SIZE-1:0][tct_pkg::EW-1:0] coloff;
      tct_pkg::lane_mask_type                              colmask;
      tct_pkg::lane_mask_type                              rowmask;
      logic                                                degen;
   } grid_type;

   grid_type          s6_in, s6_ff;
   tct_pkg::cov_type  s7_in, s7_ff;

   always_comb begin
      for (int f = 0; f < 3; f++) begin
         for (int i = 0; i < tct_pkg::TILE_SIZE; i++) begin
            s6_in.rowbase[f][i] = tct_pkg::EW'(signed'(edge_in.base[f]) +
                                  signed'(edge_in.rowstep[f]) * i);
            s6_in.coloff[f][i]  = tct_pkg::EW'(signed'(edge_in.colstep[f]) * i);
         end
      end
      s6_in.colmask = edge_in.colmask;
      s6_in.rowmask = edge_in.rowmask;
      s6_in.degen   = edge_in.degen;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s6_ff <= s6_in;
      end
   end

   always_comb begin
      logic [tct_pkg::EW-1:0] e;
      logic                   in_tri;
      s7_in.cov = '0;
      for (int r = 0; r < tct_pkg::TILE_SIZE; r++) begin
         for (int c = 0; c < tct_pkg::TILE_SIZE; c++) begin
            in_tri = 1'b1;
            for (int f = 0; f < 3; f++) begin
               e = s6_ff.rowbase[f][r] + s6_ff.coloff[f][c];
               in_tri = in_tri & ~e[tct_pkg::EW-1];
            end
            s7_in.cov[r*tct_pkg::TILE_SIZE + c] = in_tri && !s6_ff.degen &&
                                                  s6_ff.rowmask[r] && s6_ff.colmask[c];
         end
      end
      s7_in.degen = s6_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s7_ff <= s7_in;
      end
   end

   assign cov = s7_ff;

endmodule

// ===== rtl/triangle_tile_coverage_top.sv =====
// Top level of the triangle tile coverage block.
//
//  channel  direction  handshake          payload
//  req      in         valid/ready        ax ay bx by_coord cx cy tile_col tile_row
//  rsp      out        valid/ready        coverage degenerate any_hit
//  csr      in         write enable only  csr_index csr_write_data
//
// Eight register stages: one request per cycle unless a stalled response holds the
// pipe; each result is registered through every stage before it is valid on rsp.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up and a stalled response holds only the stages behind it that are full.
// Synchronous reset clears the valid bits and loads the screen size registers.
module triangle_tile_coverage_top (
   input  logic                       clock,
   input  logic                       reset,
   tct_req_if.sink                    req,
   tct_rsp_if.source                  rsp,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [tct_pkg::SCRW-1:0]   csr_write_data
);

   logic [tct_pkg::NST-1:0]   valid_ff, valid_in;
   logic [tct_pkg::NST-1:0]   en;
   logic [tct_pkg::SCRW-1:0]  width_ff, width_in;
   logic [tct_pkg::SCRW-1:0]  height_ff, height_in;
   tct_pkg::req_type          req_data;
   tct_pkg::prod_type         prod;
   tct_pkg::edge_type         edge_data;
   tct_pkg::cov_type          cov;
   tct_pkg::cov_type          out_ff, out_in;
   logic                      hit_ff, hit_in;

   always_comb begin
      en[tct_pkg::NST-1] = !valid_ff[tct_pkg::NST-1] || rsp.ready;
      for (int k = tct_pkg::NST-2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in = valid_ff;
      for (int k = 0; k < tct_pkg::NST; k++) begin
         if (en[k]) begin
            valid_in[k] = (k == 0) ? req.valid : valid_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (tct_pkg::csr_index_type'(csr_index))
            tct_pkg::CSR_SCREEN_WIDTH:  width_in  = csr_write_data;
            tct_pkg::CSR_SCREEN_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         width_ff  <= tct_pkg::WIDTH_RESET;
         height_ff <= tct_pkg::HEIGHT_RESET;
      end else begin
         valid_ff  <= valid_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req.ready = en[0];

   always_comb begin
      req_data.ax       = req.ax;
      req_data.ay       = req.ay;
      req_data.bx       = req.bx;
      req_data.by_coord = req.by_coord;
      req_data.cx       = req.cx;
      req_data.cy       = req.cy;
      req_data.tile_col = req.tile_col;
      req_data.tile_row = req.tile_row;
   end

   tct_setup u_setup (
      .clock         (clock),
      .en            (en[1:0]),
      .req           (req_data),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .prod          (prod)
   );

   tct_edge u_edge (
      .clock    (clock),
      .en       (en[4:2]),
      .prod     (prod),
      .edge_out (edge_data)
   );

   tct_raster u_raster (
      .clock   (clock),
      .en      (en[6:5]),
      .edge_in (edge_data),
      .cov     (cov)
   );

   assign out_in = cov;
   assign hit_in = |cov.cov;

   always_ff @(posedge clock) begin
      if (en[tct_pkg::NST-1]) begin
         out_ff <= out_in;
         hit_ff <= hit_in;
      end
   end

   assign rsp.valid      = valid_ff[tct_pkg::NST-1];
   assign rsp.coverage   = out_ff.cov;
   assign rsp.degenerate = out_ff.degen;
   assign rsp.any_hit    = hit_ff;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the triangle tile coverage block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [tct_pkg::COVW-1:0] coverage;
      logic                     degenerate;
      logic                     any_hit;
   } tile_result_type;

   class coverage_scoreboard;
      tile_result_type pending[$];
      int              errors;

      function tile_result_type predict_coverage(tct_pkg::req_type r, longint half_w,
                                                 longint half_h);
         tile_result_type res;
         longint ax, ay, bx, by, cx, cy, ux, uy, vx, vy, det, sgn, absdet;
         longint x0, x1, y0, y1, x, y, wx, wy, es, et;
         ax = longint'(r.ax); ay = longint'(r.ay);
         bx = longint'(r.bx); by = longint'(r.by_coord);
         cx = longint'(r.cx); cy = longint'(r.cy);
         ux = bx - ax; uy = by - ay;
         vx = cx - ax; vy = cy - ay;
         det = ux * vy - uy * vx;
         res.coverage = '0;
         res.degenerate = (det == 0);
         if (det != 0) begin
            sgn = (det > 0) ? 1 : -1;
            absdet = det * sgn;
            // round half up to a pixel: floor((v + half) / 2^F)
            x0 = (((ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx))
                  + tct_pkg::HALF) >>> tct_pkg::FRACTION_BITS;
            x1 = (((ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx))
                  + tct_pkg::HALF) >>> tct_pkg::FRACTION_BITS;
            y0 = (((ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy))
                  + tct_pkg::HALF) >>> tct_pkg::FRACTION_BITS;
            y1 = (((ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy))
                  + tct_pkg::HALF) >>> tct_pkg::FRACTION_BITS;
            for (int row = 0; row < tct_pkg::TILE_SIZE; row++) begin
               y = longint'(r.tile_row) * tct_pkg::TILE_SIZE + row;
               for (int col = 0; col < tct_pkg::TILE_SIZE; col++) begin
                  x = longint'(r.tile_col) * tct_pkg::TILE_SIZE + col;
                  if (x < x0 || x >= x1 || y < y0 || y >= y1) continue;
                  if (((x < 0) ? -x : x) >= half_w || ((y < 0) ? -y : y) >= half_h)
                     continue;
                  wx = (x << tct_pkg::FRACTION_BITS) - ax;
                  wy = (y << tct_pkg::FRACTION_BITS) - ay;
                  es = (wx * vy - wy * vx) * sgn;
                  et = (ux * wy - uy * wx) * sgn;
                  if (es < 0 || et < 0 || es + et > absdet) continue;
                  res.coverage[row * tct_pkg::TILE_SIZE + col] = 1'b1;
               end
            end
         end
         res.any_hit = (res.coverage != '0);
         return res;
      endfunction

      function void note_request(tct_pkg::req_type r, longint half_w, longint half_h);
         pending.push_back(predict_coverage(r, half_w, half_h));
      endfunction

      function void check_result(logic [tct_pkg::COVW-1:0] cov, logic degen, logic hit);
         tile_result_type exp_res;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result cov=%h degenerate=%b any_hit=%b",
                     $time, cov, degen, hit);
            errors++;
            return;
         end
         exp_res = pending.pop_front();
         if (cov !== exp_res.coverage) begin
            $display("%0t: coverage expected %h actual %h", $time, exp_res.coverage, cov);
            errors++;
         end
         if (degen !== exp_res.degenerate) begin
            $display("%0t: degenerate expected %b actual %b", $time,
                     exp_res.degenerate, degen);
            errors++;
         end
         if (hit !== exp_res.any_hit) begin
            $display("%0t: any_hit expected %b actual %b", $time, exp_res.any_hit, hit);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        csr_write_enable;
   logic                        csr_index;
   logic [tct_pkg::SCRW-1:0]    csr_write_data;

   tct_req_if req ();
   tct_rsp_if rsp ();

   triangle_tile_coverage_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   coverage_scoreboard sb = new();
   longint half_w = 320;
   longint half_h = 240;
   int     send_idle_pct;
   int     recv_idle_pct;
   bit     hold_request;
   int     hold_left;
   int     quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 300;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_result(rsp.coverage, rsp.degenerate,
                                                            rsp.any_hit);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(tct_pkg::req_type r);
      req.valid    <= 1'b1;
      req.ax       <= r.ax;
      req.ay       <= r.ay;
      req.bx       <= r.bx;
      req.by_coord <= r.by_coord;
      req.cx       <= r.cx;
      req.cy       <= r.cy;
      req.tile_col <= r.tile_col;
      req.tile_row <= r.tile_row;
      do @(posedge clock); while (!req.ready);
      sb.note_request(r, half_w, half_h);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_screen(logic [tct_pkg::SCRW-1:0] w, logic [tct_pkg::SCRW-1:0] h);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= tct_pkg::CSR_SCREEN_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      csr_index        <= tct_pkg::CSR_SCREEN_HEIGHT;
      csr_write_data   <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      half_w = longint'(w) / 2;
      half_h = longint'(h) / 2;
   endtask

   function automatic tct_pkg::req_type make_tri(int ax, int ay, int bx, int by,
                                                 int cx, int cy, int tc, int tr);
      tct_pkg::req_type r;
      r.ax       = tct_pkg::CW'(ax);
      r.ay       = tct_pkg::CW'(ay);
      r.bx       = tct_pkg::CW'(bx);
      r.by_coord = tct_pkg::CW'(by);
      r.cx       = tct_pkg::CW'(cx);
      r.cy       = tct_pkg::CW'(cy);
      r.tile_col = tct_pkg::TW'(tc);
      r.tile_row = tct_pkg::TW'(tr);
      return r;
   endfunction

   function automatic tct_pkg::req_type random_tri();
      tct_pkg::req_type r;
      logic [127:0]     raw;
      int tc, tr, ox, oy, spread, pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         raw = {$urandom, $urandom, $urandom, $urandom};
         r = raw[$bits(tct_pkg::req_type)-1:0];
         return r;
      end
      tc = $urandom_range(80) - 40;
      tr = $urandom_range(80) - 40;
      spread = (pick < 60) ? 200 : ((pick < 85) ? 1200 : 6000);
      ox = tc * 128 + 64;
      oy = tr * 128 + 64;
      r = make_tri(ox + $urandom_range(2 * spread) - spread,
                   oy + $urandom_range(2 * spread) - spread,
                   ox + $urandom_range(2 * spread) - spread,
                   oy + $urandom_range(2 * spread) - spread,
                   ox + $urandom_range(2 * spread) - spread,
                   oy + $urandom_range(2 * spread) - spread,
                   tc, tr);
      if (pick >= 95) begin
         // collinear: C on line AB
         r.cx = tct_pkg::CW'(r.ax + 2 * (r.bx - r.ax));
         r.cy = tct_pkg::CW'(r.ay + 2 * (r.by_coord - r.ay));
      end
      return r;
   endfunction

   initial begin
      tct_pkg::req_type directed[$];
      logic [tct_pkg::SCRW-1:0] widths[8]  = '{640, 2, 4096, 8191, 0, 1, 130, 1000};
      logic [tct_pkg::SCRW-1:0] heights[8] = '{480, 4096, 2, 8191, 1, 0, 90, 77};
      reset = 1'b1;
      req.valid = 1'b0;
      {req.ax, req.ay, req.bx, req.by_coord, req.cx, req.cy} = '0;
      req.tile_col = '0;
      req.tile_row = '0;
      csr_write_enable = 1'b0;
      csr_index = tct_pkg::CSR_SCREEN_WIDTH;
      csr_write_data = '0;
      hold_request = 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 78;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_tri(0, 0, 128, 0, 0, 128, 0, 0));
      directed.push_back(make_tri(0, 0, 0, 128, 128, 0, 0, 0));
      directed.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
      directed.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, -256, -256));
      directed.push_back(make_tri(32767, 32767, -32768, 32767, 32767, -32768, 255, 255));
      directed.push_back(make_tri(-32768, -32768, 32767, 32767, -32768, 32767, 255, -256));
      directed.push_back(make_tri(8, 8, 120, 8, 8, 120, 0, 0));
      directed.push_back(make_tri(-8, -8, 136, -8, -8, 136, 0, 0));
      directed.push_back(make_tri(-120, -120, -8, -120, -120, -8, -1, -1));
      directed.push_back(make_tri(0, 0, 16, 16, 32, 32, 0, 0));
      directed.push_back(make_tri(0, 0, 1, 0, 0, 1, 0, 0));
      directed.push_back(make_tri(0, 0, 1024, 8, 8, 1024, 0, 0));
      directed.push_back(make_tri(-5000, -5000, 5000, -5000, 0, 5000, 39, 29));
      directed.push_back(make_tri(-5000, -5000, 5000, -5000, 0, 5000, 40, 30));
      directed.push_back(make_tri(-5000, -5000, 5000, -5000, 0, 5000, -41, -31));
      directed.push_back(make_tri(16, 0, 16, 16, 16, 128, 0, 0));
      directed.push_back(make_tri(0, 0, 4096, 0, 0, 4096, 1, 2));
      directed.push_back(make_tri(4096, 0, 0, 0, 0, 4096, 3, 3));
      directed.push_back(make_tri(7, 9, 130, 7, 9, 130, 0, 0));
      foreach (directed[i]) send_request(directed[i]);

      for (int phase = 0; phase < 8; phase++) begin
         drain_results();
         write_screen(widths[phase], heights[phase]);
         if (phase < 3) begin
            send_idle_pct = 19; recv_idle_pct = 78;
         end else if (phase < 6) begin
            send_idle_pct = 78; recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if (phase == 6) begin
            // receiver holds off while the sender keeps offering
            hold_request = 1'b1;
         end
         repeat (200) send_request(random_tri());
      end

      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
